@@ rtl/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;
	localparam int CPW    = 21;

	localparam logic [7:0]  BOM_FE    = 8'hFE;
	localparam logic [7:0]  BOM_FF    = 8'hFF;
	localparam logic [15:0] SURR_LO   = 16'hD800;
	localparam logic [15:0] SURR_HI   = 16'hDFFF;
	localparam logic [CPW-1:0] SUPP_BASE = 21'h10000;

	localparam logic [1:0] LEN1 = 2'd0;
	localparam logic [1:0] LEN2 = 2'd1;
	localparam logic [1:0] LEN3 = 2'd2;
	localparam logic [1:0] LEN4 = 2'd3;

	typedef enum logic [1:0] {
		PH_MARK1 = 2'd0,
		PH_MARK2 = 2'd1,
		PH_RUN   = 2'd2,
		PH_BAD   = 2'd3
	} phase_t;

	// one queued job: either a code point or a bad-mark error
	typedef struct packed {
		logic           err;
		logic [CPW-1:0] cp;
	} job_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	// encoded length minus one
	function automatic logic [1:0] utf8_lenm1(input logic [CPW-1:0] cp);
		logic [1:0] l;
		if (cp < 21'd128)
			l = LEN1;
		else if (cp < 21'd2048)
			l = LEN2;
		else if (cp < 21'd65536)
			l = LEN3;
		else
			l = LEN4;
		return l;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [CPW-1:0] cp,
	                                         input logic [1:0] lenm1,
	                                         input logic [1:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		case (lenm1)
			LEN1: b = {1'b0, cp[6:0]};
			LEN2: begin
				if (idx == 2'd0)
					b = {3'b110, cp[10:6]};
			end
			LEN3: begin
				if (idx == 2'd0)
					b = {4'b1110, cp[15:12]};
				else if (idx == 2'd1)
					b = {2'b10, cp[11:6]};
			end
			LEN4: begin
				if (idx == 2'd0)
					b = {5'b11110, cp[20:18]};
				else if (idx == 2'd1)
					b = {2'b10, cp[17:12]};
				else if (idx == 2'd2)
					b = {2'b10, cp[11:6]};
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts input bytes, checks the byte order mark, assembles code units and
// surrogate pairs, and pushes code points or errors into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_stall,
	input  wire logic [7:0]      in_byte,
	input  wire logic            restart,
	input  wire logic            q_full,
	output      logic            push,
	output      u16u8_pkg::job_t push_job
);
	import u16u8_pkg::*;

	phase_t      phase_q, phase_n;
	logic [7:0]  mark_first_q, mark_first_n;
	logic        little_q, little_n;
	logic        half_valid_q, half_valid_n;
	logic [7:0]  half_byte_q, half_byte_n;
	logic        high_pend_q, high_pend_n;
	logic [9:0]  high_bits_q, high_bits_n;

	logic        accept;
	phase_t      eff_phase;
	logic [15:0] unit;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MARK1;
			mark_first_q <= '0;
			little_q     <= 1'b0;
			half_valid_q <= 1'b0;
			half_byte_q  <= '0;
			high_pend_q  <= 1'b0;
			high_bits_q  <= '0;
		end else begin
			phase_q      <= phase_n;
			mark_first_q <= mark_first_n;
			little_q     <= little_n;
			half_valid_q <= half_valid_n;
			half_byte_q  <= half_byte_n;
			high_pend_q  <= high_pend_n;
			high_bits_q  <= high_bits_n;
		end
	end

	always_comb begin
		phase_n      = phase_q;
		mark_first_n = mark_first_q;
		little_n     = little_q;
		half_valid_n = half_valid_q;
		half_byte_n  = half_byte_q;
		high_pend_n  = high_pend_q;
		high_bits_n  = high_bits_q;
		push         = 1'b0;
		push_job     = '0;
		eff_phase    = restart ? PH_MARK1 : phase_q;
		unit         = little_q ? {in_byte, half_byte_q} : {half_byte_q, in_byte};

		if (accept) begin
			case (eff_phase)
				PH_MARK1: begin
					mark_first_n = in_byte;
					phase_n      = PH_MARK2;
					little_n     = 1'b0;
					half_valid_n = 1'b0;
					half_byte_n  = '0;
					high_pend_n  = 1'b0;
					high_bits_n  = '0;
				end
				PH_MARK2: begin
					if (mark_first_q == BOM_FE && in_byte == BOM_FF) begin
						little_n = 1'b0;
						phase_n  = PH_RUN;
					end else if (mark_first_q == BOM_FF && in_byte == BOM_FE) begin
						little_n = 1'b1;
						phase_n  = PH_RUN;
					end else begin
						phase_n      = PH_BAD;
						push         = 1'b1;
						push_job.err = 1'b1;
					end
				end
				PH_RUN: begin
					if (!half_valid_q) begin
						half_byte_n  = in_byte;
						half_valid_n = 1'b1;
					end else begin
						half_valid_n = 1'b0;
						if (high_pend_q) begin
							high_pend_n = 1'b0;
							high_bits_n = '0;
							push        = 1'b1;
							push_job.cp = SUPP_BASE + {1'b0, high_bits_q, unit[9:0]};
						end else if (unit >= SURR_LO && unit <= SURR_HI) begin
							high_pend_n = 1'b1;
							high_bits_n = unit[9:0];
						end else begin
							push        = 1'b1;
							push_job.cp = {5'd0, unit};
						end
					end
				end
				PH_BAD: ;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Short register FIFO of jobs between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire u16u8_pkg::job_t      push_job,
	input  wire logic                 pop,
	output      u16u8_pkg::job_t      head,
	output      u16u8_pkg::q_status_t status
);
	import u16u8_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head             = mem_q[rd_ptr_q];
	assign status.full      = (count_q == QCW'(QDEPTH));
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

@@ rtl/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Pops jobs and emits UTF-8 bytes one per cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire u16u8_pkg::job_t      head,
	input  wire u16u8_pkg::q_status_t q_status,
	output      logic                 pop,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [7:0]           out_byte,
	output      logic                 last,
	output      logic                 status
);
	import u16u8_pkg::*;

	logic           busy_q;
	logic [CPW-1:0] cp_q;
	logic [1:0]     idx_q;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           last_q;
	logic           status_q;

	logic           can_load;
	logic           fire;
	logic [CPW-1:0] src_cp;
	logic           src_err;
	logic [1:0]     idx;
	logic [1:0]     lenm1;
	logic           is_last;

	assign can_load = !out_valid_q || !out_stall;
	assign src_cp   = busy_q ? cp_q : head.cp;
	assign src_err  = !busy_q && head.err;
	assign idx      = busy_q ? idx_q : 2'd0;
	assign lenm1    = src_err ? LEN1 : utf8_lenm1(src_cp);
	assign is_last  = (idx == lenm1);
	assign fire     = can_load && (busy_q || q_status.not_empty);
	assign pop      = fire && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q      <= !is_last;
				idx_q       <= idx + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cp_q       <= src_cp;
			out_byte_q <= src_err ? 8'd0 : utf8_byte(src_cp, lenm1, idx);
			last_q     <= is_last;
			status_q   <= src_err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign status    = status_q;

endmodule

`default_nettype wire

@@ rtl/utf16_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a UTF-16 byte stream with a leading byte order mark into UTF-8
// bytes, marking the final byte of each code point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_stall  | in_byte[7:0], restart
//  out     | source    | out_valid / out_stall| out_byte[7:0], last, status
//
//  One input byte is taken per cycle while the job queue has room.
//  One output byte leaves per cycle while out_stall is low; a code point gives
//  1 to 4 bytes, so a unit of two input bytes gives up to 3 output bytes and a
//  surrogate pair of four input bytes up to 4.
//  With the queue idle, the completing byte's job passes the queue and the output register before out_valid rises.
//  Reset clears the mark detector, the four-entry queue and the output stage.
//  Output stalls back up through the queue to in_stall only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       restart,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] out_byte,
	output      logic       last,
	output      logic       status
);
	import u16u8_pkg::*;

	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head;
	q_status_t q_status;

	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.restart  (restart),
		.q_full   (q_status.full),
		.push     (push),
		.push_job (push_job)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && out_byte == 8'd0)
		else $error("error transaction not single zero byte");

	a_lead_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> out_byte[7])
		else $error("non-final byte lacks top bit");

	a_last_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && !status |-> !(out_byte[7] && out_byte[6]))
		else $error("final byte is a lead byte");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.not_empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into full queue");

endmodule

`default_nettype wire

@@ bench/tb_utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Drives UTF-16 byte streams into the transcoder and checks every UTF-8
// output transaction against a byte-level transcoding model kept in the
// bench. A short directed table covers both byte order marks, a bad mark,
// the encoding length boundaries and surrogate pairs. Random streams follow,
// mostly well formed with some bad marks and cut-off units, under several
// mixes of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;
	import u16u8_pkg::*;

	localparam int   CYCLE_LIMIT  = 400000;
	localparam logic ST_DATA      = 1'b0;
	localparam logic ST_BAD_MARK  = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       err;
	} utf8_res_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        rs;
		logic        typed;
		logic [2:0]  cnt;
		logic [31:0] ebytes;
		logic        err;
	} stim_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       restart   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last;
	logic       status;

	// transcoding model state
	phase_t     tr_phase;
	logic [7:0] mark_b;
	logic       le_order;
	logic       half_ok;
	logic [7:0] half_b;
	logic       surr_wait;
	logic [9:0] surr_bits;
	utf8_res_t  res_buf [4];
	int         res_cnt;

	utf8_res_t  utf8_expected [$];
	utf8_res_t  head_res;
	stim_row_t  dir_tab [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int sent_items    = 0;
	int fail_cnt      = 0;
	int cyc_cnt       = 0;

	utf16_to_utf8_transcoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output side: check accepted transactions, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected transaction: out_byte %h last %b status %b",
				       out_byte, last, status);
				fail_cnt++;
			end else begin
				head_res = utf8_expected.pop_front();
				if (out_byte !== head_res.data) begin
					$error("out_byte: expected %h, got %h", head_res.data, out_byte);
					fail_cnt++;
				end
				if (last !== head_res.fin) begin
					$error("last: expected %b, got %b", head_res.fin, last);
					fail_cnt++;
				end
				if (status !== head_res.err) begin
					$error("status: expected %b, got %b", head_res.err, status);
					fail_cnt++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic clear_state();
		tr_phase  = PH_MARK1;
		mark_b    = 8'h00;
		le_order  = 1'b0;
		half_ok   = 1'b0;
		half_b    = 8'h00;
		surr_wait = 1'b0;
		surr_bits = 10'h000;
	endtask

	task automatic utf8_encode(input logic [20:0] cp);
		int k;
		logic [20:0] sh;
		logic [7:0] lead;
		if (cp < 21'd128)
			res_cnt = 1;
		else if (cp < 21'd2048)
			res_cnt = 2;
		else if (cp < 21'h10000)
			res_cnt = 3;
		else
			res_cnt = 4;
		case (res_cnt)
			1: lead = cp[7:0];
			2: lead = {3'b110, cp[10:6]};
			3: lead = {4'b1110, cp[15:12]};
			default: lead = {5'b11110, cp[20:18]};
		endcase
		for (k = 0; k < res_cnt; k++) begin
			sh = cp >> (6 * (res_cnt - 1 - k));
			res_buf[k] = {(k == 0) ? lead : {2'b10, sh[5:0]}, (k == res_cnt - 1), ST_DATA};
		end
	endtask

	task automatic transcode_byte(input logic [7:0] b, input logic rs);
		logic [15:0] unit;
		res_cnt = 0;
		if (rs)
			clear_state();
		case (tr_phase)
			PH_MARK1: begin
				mark_b   = b;
				tr_phase = PH_MARK2;
			end
			PH_MARK2: begin
				if (mark_b == BOM_FE && b == BOM_FF) begin
					le_order = 1'b0;
					tr_phase = PH_RUN;
				end else if (mark_b == BOM_FF && b == BOM_FE) begin
					le_order = 1'b1;
					tr_phase = PH_RUN;
				end else begin
					tr_phase   = PH_BAD;
					res_buf[0] = {8'h00, 1'b1, ST_BAD_MARK};
					res_cnt    = 1;
				end
			end
			PH_BAD: ;
			default: begin
				if (!half_ok) begin
					half_b  = b;
					half_ok = 1'b1;
				end else begin
					half_ok = 1'b0;
					unit = le_order ? {b, half_b} : {half_b, b};
					if (surr_wait) begin
						surr_wait = 1'b0;
						utf8_encode(21'h10000 + {surr_bits, unit[9:0]});
						surr_bits = 10'h000;
					end else if (unit >= SURR_LO && unit <= SURR_HI) begin
						surr_wait = 1'b1;
						surr_bits = unit[9:0];
					end else begin
						utf8_encode({5'd0, unit});
					end
				end
			end
		endcase
	endtask

	function automatic stim_row_t dir_row(input logic [7:0] b, input logic rs,
	                                      input logic typed, input logic [2:0] cnt,
	                                      input logic [31:0] eb, input logic err);
		return {b, rs, typed, cnt, eb, err};
	endfunction

	task automatic send_row(input stim_row_t r);
		int gap, k;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= r.data;
		restart  <= r.rs;
		do @(posedge clk); while (in_stall);
		sent_items++;
		transcode_byte(r.data, r.rs);
		if (r.typed) begin
			for (k = 0; k < r.cnt; k++)
				utf8_expected.push_back({r.ebytes[31 - 8 * k -: 8], (k == r.cnt - 1), r.err});
		end else begin
			for (k = 0; k < res_cnt; k++)
				utf8_expected.push_back(res_buf[k]);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic rs);
		send_row(dir_row(b, rs, 1'b0, 3'd0, 32'h0, ST_DATA));
	endtask

	task automatic send_unit(input logic [15:0] u, input logic le);
		if (le) begin
			send_byte(u[7:0], 1'b0);
			send_byte(u[15:8], 1'b0);
		end else begin
			send_byte(u[15:8], 1'b0);
			send_byte(u[7:0], 1'b0);
		end
	endtask

	task automatic random_stream();
		int kind, n, k;
		logic le;
		logic [15:0] u;
		kind = $urandom_range(99);
		if (kind < 12) begin
			// mostly a bad mark, then bytes that should be ignored
			case ($urandom_range(3))
				0: begin
					send_byte(BOM_FE, 1'b1);
					send_byte(BOM_FE, 1'b0);
				end
				1: begin
					send_byte(BOM_FF, 1'b1);
					send_byte(BOM_FF, 1'b0);
				end
				2: begin
					send_byte(BOM_FE, 1'b1);
					send_byte(8'($urandom_range(255)), 1'b0);
				end
				default: begin
					send_byte(8'($urandom_range(255)), 1'b1);
					send_byte(8'($urandom_range(255)), 1'b0);
				end
			endcase
			n = $urandom_range(3);
			for (k = 0; k < n; k++)
				send_byte(8'($urandom_range(255)), 1'b0);
		end else begin
			le = 1'($urandom_range(1));
			send_byte(le ? BOM_FF : BOM_FE, 1'b1);
			send_byte(le ? BOM_FE : BOM_FF, 1'b0);
			n = $urandom_range(1, 8);
			for (k = 0; k < n; k++) begin
				case ($urandom_range(9))
					0, 1: u = 16'($urandom_range(127));
					2: u = 16'($urandom_range(16'h7FF, 16'h80));
					3, 4: u = 16'($urandom_range(16'hFFFF, 16'h800));
					5, 6: begin
						send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), le);
						u = 16'($urandom_range(16'hDFFF, 16'hDC00));
					end
					7: begin
						// low surrogate leading, arbitrary partner
						send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), le);
						u = 16'($urandom_range(16'hFFFF));
					end
					8: u = 16'($urandom_range(16'hFFFF));
					default: begin
						case ($urandom_range(5))
							0: u = 16'h0000;
							1: u = 16'h007F;
							2: u = 16'h0080;
							3: u = 16'h07FF;
							4: u = 16'h0800;
							default: u = 16'hFFFF;
						endcase
					end
				endcase
				send_unit(u, le);
			end
			// cut-off tail, dropped by the next restart
			if (kind < 24) begin
				if ($urandom_range(1))
					send_byte(8'($urandom_range(255)), 1'b0);
				else
					send_unit(16'($urandom_range(16'hDFFF, 16'hD800)), le);
			end
		end
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		do @(posedge clk); while (utf8_expected.size() != 0);
	endtask

	initial begin : stimulus
		int ph, target, k;
		clear_state();

		// big endian stream straight after reset, no restart needed
		dir_tab.push_back(dir_row(BOM_FE, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(BOM_FF, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd1, 32'h00000000, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h7F, 1'b0, 1'b1, 3'd1, 32'h7F000000, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h80, 1'b0, 1'b1, 3'd2, 32'hC2800000, ST_DATA));
		dir_tab.push_back(dir_row(8'h07, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b1, 3'd2, 32'hDFBF0000, ST_DATA));
		dir_tab.push_back(dir_row(8'h08, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd3, 32'hE0A08000, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b1, 3'd3, 32'hEFBFBF00, ST_DATA));
		// lowest surrogate pair
		dir_tab.push_back(dir_row(8'hD8, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hDC, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'h00, 1'b0, 1'b1, 3'd4, 32'hF0908080, ST_DATA));
		// little endian, high unit DBFF with partner FFFF, giving the highest code point
		dir_tab.push_back(dir_row(BOM_FF, 1'b1, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(BOM_FE, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hDB, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b0, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(8'hFF, 1'b0, 1'b1, 3'd4, 32'hF48FBFBF, ST_DATA));
		// bad mark, then an ignored byte
		dir_tab.push_back(dir_row(BOM_FE, 1'b1, 1'b1, 3'd0, 32'h0, ST_DATA));
		dir_tab.push_back(dir_row(BOM_FE, 1'b0, 1'b1, 3'd1, 32'h0, ST_BAD_MARK));
		dir_tab.push_back(dir_row(8'h5A, 1'b0, 1'b1, 3'd0, 32'h0, ST_DATA));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < dir_tab.size(); k++)
			send_row(dir_tab[k]);

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 86;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 86;
				end
				default: begin
					send_idle_pct = 16;
					stall_pct     = 16;
				end
			endcase
			target = sent_items + 32;
			while (sent_items < target)
				random_stream();
			// source holds off until every result is out
			drain_outputs();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
